FILE: rtl/call_record_line_parser_unit_defines.svh
// Assertion helpers for the call record line parser.
`ifndef CALL_RECORD_LINE_PARSER_UNIT_DEFINES_SVH
`define CALL_RECORD_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crlp_pkg.sv
package crlp_pkg;

  localparam int unsigned REC_LEN       = 80;
  localparam int unsigned COL_W         = 8;
  localparam int unsigned VAL_W         = 7;
  localparam int unsigned NUM_VALS      = 7;
  localparam int unsigned VSEL_W        = $clog2(NUM_VALS);
  localparam int unsigned NUM_ERRS      = 5;
  localparam int unsigned DUR_W         = 19;
  localparam int unsigned HALF_W        = 60;
  localparam int unsigned CALLED_W      = 2 * HALF_W;
  localparam int unsigned CALLED_DIGITS = 30;
  localparam int unsigned CALLED_CNT_W  = $clog2(CALLED_DIGITS + 1);
  localparam int unsigned CODE_DIGITS   = 4;
  localparam int unsigned CODE_CNT_W    = $clog2(CODE_DIGITS + 1);
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_IGNORED   = 4'd1;
  localparam logic [3:0] ST_LENGTH    = 4'd2;
  localparam logic [3:0] ST_MONTH     = 4'd3;
  localparam logic [3:0] ST_DAY       = 4'd4;
  localparam logic [3:0] ST_HOUR      = 4'd5;
  localparam logic [3:0] ST_MINUTE    = 4'd6;
  localparam logic [3:0] ST_ZERO_DUR  = 4'd7;
  localparam logic [3:0] ST_CENTREX   = 4'd8;
  localparam logic [3:0] ST_CALLED    = 4'd9;
  localparam logic [3:0] ST_DUR_BAD   = 4'd10;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_P    = 8'h50;

  localparam logic [1:0] AMPM_NONE = 2'd0;
  localparam logic [1:0] AMPM_AM   = 2'd1;
  localparam logic [1:0] AMPM_PM   = 2'd2;

  // value slots
  localparam logic [VSEL_W-1:0] V_MONTH  = 3'd0;
  localparam logic [VSEL_W-1:0] V_DAY    = 3'd1;
  localparam logic [VSEL_W-1:0] V_HOUR   = 3'd2;
  localparam logic [VSEL_W-1:0] V_MINUTE = 3'd3;
  localparam logic [VSEL_W-1:0] V_DUR_H  = 3'd4;
  localparam logic [VSEL_W-1:0] V_DUR_M  = 3'd5;
  localparam logic [VSEL_W-1:0] V_DUR_S  = 3'd6;

  localparam logic [2:0] ERR_MONTH  = 3'd0;
  localparam logic [2:0] ERR_DAY    = 3'd1;
  localparam logic [2:0] ERR_HOUR   = 3'd2;
  localparam logic [2:0] ERR_MINUTE = 3'd3;
  localparam logic [2:0] ERR_DUR    = 3'd4;

  localparam logic [COL_W-1:0] COL_MONTH_T  = 8'd0;
  localparam logic [COL_W-1:0] COL_MONTH_U  = 8'd1;
  localparam logic [COL_W-1:0] COL_DAY_T    = 8'd3;
  localparam logic [COL_W-1:0] COL_DAY_U    = 8'd4;
  localparam logic [COL_W-1:0] COL_YEAR_HI  = 8'd6;
  localparam logic [COL_W-1:0] COL_YEAR_LO  = 8'd7;
  localparam logic [COL_W-1:0] COL_HOUR_T   = 8'd10;
  localparam logic [COL_W-1:0] COL_HOUR_U   = 8'd11;
  localparam logic [COL_W-1:0] COL_MIN_T    = 8'd13;
  localparam logic [COL_W-1:0] COL_MIN_U    = 8'd14;
  localparam logic [COL_W-1:0] COL_AMPM     = 8'd15;
  localparam logic [COL_W-1:0] COL_CALLER0  = 8'd19;
  localparam logic [COL_W-1:0] COL_CALLER1  = 8'd20;
  localparam logic [COL_W-1:0] COL_CENTREX  = 8'd26;
  localparam logic [COL_W-1:0] COL_CALLED_F = 8'd27;
  localparam logic [COL_W-1:0] COL_CALLED_L = 8'd56;
  localparam logic [COL_W-1:0] COL_DH_T     = 8'd64;
  localparam logic [COL_W-1:0] COL_DH_U     = 8'd65;
  localparam logic [COL_W-1:0] COL_DM_T     = 8'd67;
  localparam logic [COL_W-1:0] COL_DM_U     = 8'd68;
  localparam logic [COL_W-1:0] COL_DS_T     = 8'd70;
  localparam logic [COL_W-1:0] COL_DS_U     = 8'd71;
  localparam logic [COL_W-1:0] COL_CODE_F   = 8'd74;
  localparam logic [COL_W-1:0] COL_CODE_L   = 8'd77;
  localparam logic [COL_W-1:0] COL_PREFIX   = 8'd6;
  localparam logic [COL_W-1:0] COL_MAX      = 8'd255;

  localparam logic [HALF_W-1:0] FILL60    = {HALF_W{1'b1}};
  localparam logic [HALF_W-1:0] ZERO_NUM  = {4'h0, {(HALF_W-4){1'b1}}};
  localparam logic [15:0]       CODE_FILL = 16'hFFFF;
  localparam logic [15:0]       CODE_ZERO = 16'h0FFF;

  typedef struct packed {
    logic                  ignored;
    logic                  len_bad;
    logic [VAL_W-1:0]      month;
    logic [VAL_W-1:0]      day;
    logic [VAL_W-1:0]      hour;
    logic [VAL_W-1:0]      minute;
    logic [1:0]            ampm;
    logic [NUM_ERRS-1:0]   derr;
    logic [15:0]           year;
    logic [15:0]           caller;
    logic [15:0]           code;
    logic                  code_any;
    logic [CALLED_W-1:0]   called;
    logic                  called_any;
    logic                  called_nondigit;
    logic                  centrex;
    logic [VAL_W-1:0]      dur_h;
    logic [VAL_W-1:0]      dur_m;
    logic [VAL_W-1:0]      dur_s;
  } line_rec_t;

  // "  Date" prefix of a header line
  function automatic logic [7:0] date_word(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_SP;
      3'd1:    ch = CH_SP;
      3'd2:    ch = 8'h44;
      3'd3:    ch = 8'h61;
      3'd4:    ch = 8'h74;
      3'd5:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/call_record_line_parser_unit.sv
// On its LF a line's record enters the line queue, then the output register.
// Throughput: one byte per cycle; the two-entry line queue and output register
// absorb output stalls, and input stalls only once both queue entries are full.
// Reset: synchronous, active low; clears column, line state, queue and output valid.
`include "call_record_line_parser_unit_defines.svh"
module call_record_line_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_status,
  output logic [15:0]                 out_year_text,
  output logic [3:0]                  out_start_month,
  output logic [4:0]                  out_start_day,
  output logic [4:0]                  out_start_hour,
  output logic [5:0]                  out_start_minute,
  output logic [crlp_pkg::DUR_W-1:0]  out_duration_seconds,
  output logic [15:0]                 out_caller_text,
  output logic [15:0]                 out_code_digits,
  output logic [crlp_pkg::HALF_W-1:0] out_called_first_half,
  output logic [crlp_pkg::HALF_W-1:0] out_called_second_half
);
  import crlp_pkg::*;

  logic      accept;
  logic      push, pop, q_valid, q_full;
  line_rec_t push_rec, head_rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  crlp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .rec     (push_rec)
  );

  crlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_valid (q_valid),
    .head_rec   (head_rec),
    .full       (q_full)
  );

  crlp_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head_valid             (q_valid),
    .head_rec               (head_rec),
    .pop                    (pop),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_status             (out_status),
    .out_year_text          (out_year_text),
    .out_start_month        (out_start_month),
    .out_start_day          (out_start_day),
    .out_start_hour         (out_start_hour),
    .out_start_minute       (out_start_minute),
    .out_duration_seconds   (out_duration_seconds),
    .out_caller_text        (out_caller_text),
    .out_code_digits        (out_code_digits),
    .out_called_first_half  (out_called_first_half),
    .out_called_second_half (out_called_second_half)
  );

  `CRLP_ASSERT_IMP(a_err_fields_zero, clk, rst_n, out_valid && out_status != ST_OK, out_duration_seconds == '0 && out_caller_text == 16'h0 && out_called_first_half == '0, "failed line carries data")
  `CRLP_ASSERT_IMP(a_ok_ranges, clk, rst_n, out_valid && out_status == ST_OK, out_start_hour <= 5'd23 && out_start_month <= 4'd12 && out_duration_seconds != '0, "accepted line out of range")
  `CRLP_ASSERT_NXT(a_drain, clk, rst_n, out_valid && !out_stall && !q_valid, !out_valid, "result repeated")

endmodule

FILE: rtl/crlp_front.sv
module crlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output crlp_pkg::line_rec_t rec
);
  import crlp_pkg::*;

  logic [COL_W-1:0]        col_r, col_nxt;
  logic                    last_cr_r, last_cr_nxt;
  logic                    special_r, special_nxt;
  logic                    date_match_r, date_match_nxt;
  logic [VAL_W-1:0]        val_r [NUM_VALS];
  logic [VAL_W-1:0]        val_nxt [NUM_VALS];
  logic [1:0]              ampm_r, ampm_nxt;
  logic [NUM_ERRS-1:0]     derr_r, derr_nxt;
  logic [15:0]             year_r, year_nxt;
  logic [15:0]             caller_r, caller_nxt;
  logic [1:0]              caller_cnt_r, caller_cnt_nxt;
  logic [15:0]             code_r, code_nxt;
  logic [CODE_CNT_W-1:0]   code_cnt_r, code_cnt_nxt;
  logic [CALLED_W-1:0]     called_r, called_nxt;
  logic [CALLED_CNT_W-1:0] called_cnt_r, called_cnt_nxt;
  logic                    nondigit_r, nondigit_nxt;
  logic                    centrex_r, centrex_nxt;

  logic                    eol;
  logic                    is_dig, is_sp;
  logic [3:0]              dval;
  logic                    take, tens, sp_ok;
  logic [VSEL_W-1:0]       sel;
  logic [2:0]              err_idx;
  logic [VAL_W-1:0]        digit_v;

  assign eol    = (rx_byte == CH_LF) && last_cr_r;
  assign push   = accept && eol;
  assign is_dig = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign is_sp  = (rx_byte == CH_SP);
  assign dval   = is_dig ? rx_byte[3:0] : 4'd0;

  // pick the two-digit field that owns this column
  always_comb begin
    take  = 1'b1;
    tens  = 1'b0;
    sp_ok = 1'b0;
    sel   = V_MONTH;
    case (col_r)
      COL_MONTH_T: begin sel = V_MONTH;  tens = 1'b1; sp_ok = 1'b1; end
      COL_MONTH_U: begin sel = V_MONTH;  end
      COL_DAY_T:   begin sel = V_DAY;    tens = 1'b1; sp_ok = 1'b1; end
      COL_DAY_U:   begin sel = V_DAY;    end
      COL_HOUR_T:  begin sel = V_HOUR;   tens = 1'b1; sp_ok = 1'b1; end
      COL_HOUR_U:  begin sel = V_HOUR;   end
      COL_MIN_T:   begin sel = V_MINUTE; tens = 1'b1; end
      COL_MIN_U:   begin sel = V_MINUTE; end
      COL_DH_T:    begin sel = V_DUR_H;  tens = 1'b1; end
      COL_DH_U:    begin sel = V_DUR_H;  end
      COL_DM_T:    begin sel = V_DUR_M;  tens = 1'b1; end
      COL_DM_U:    begin sel = V_DUR_M;  end
      COL_DS_T:    begin sel = V_DUR_S;  tens = 1'b1; end
      COL_DS_U:    begin sel = V_DUR_S;  end
      default:     take = 1'b0;
    endcase
    err_idx = (sel >= V_DUR_H) ? ERR_DUR : sel;
    digit_v = tens ? (VAL_W'({dval, 3'b000}) + VAL_W'({dval, 1'b0}))
                   : (val_r[sel] + VAL_W'(dval));
  end

  always_comb begin
    col_nxt        = col_r;
    last_cr_nxt    = last_cr_r;
    special_nxt    = special_r;
    date_match_nxt = date_match_r;
    val_nxt        = val_r;
    ampm_nxt       = ampm_r;
    derr_nxt       = derr_r;
    year_nxt       = year_r;
    caller_nxt     = caller_r;
    caller_cnt_nxt = caller_cnt_r;
    code_nxt       = code_r;
    code_cnt_nxt   = code_cnt_r;
    called_nxt     = called_r;
    called_cnt_nxt = called_cnt_r;
    nondigit_nxt   = nondigit_r;
    centrex_nxt    = centrex_r;
    if (accept) begin
      if (eol) begin
        // line done: drop back to the empty-line state
        col_nxt        = '0;
        last_cr_nxt    = 1'b0;
        special_nxt    = 1'b0;
        date_match_nxt = 1'b1;
        for (int i = 0; i < NUM_VALS; i++) val_nxt[i] = '0;
        ampm_nxt       = AMPM_NONE;
        derr_nxt       = '0;
        year_nxt       = '0;
        caller_nxt     = '0;
        caller_cnt_nxt = '0;
        code_nxt       = CODE_FILL;
        code_cnt_nxt   = '0;
        called_nxt     = {FILL60, FILL60};
        called_cnt_nxt = '0;
        nondigit_nxt   = 1'b0;
        centrex_nxt    = 1'b0;
      end else begin
        last_cr_nxt = (rx_byte == CH_CR);
        col_nxt     = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
        if (col_r < COL_PREFIX && rx_byte != date_word(col_r[2:0])) date_match_nxt = 1'b0;
        if (col_r == COL_MONTH_T && (rx_byte == CH_CR || rx_byte == CH_DASH))
          special_nxt = 1'b1;
        if (take) begin
          val_nxt[sel] = digit_v;
          if (!(is_dig || (sp_ok && is_sp))) derr_nxt[err_idx] = 1'b1;
        end
        if (col_r == COL_YEAR_HI) year_nxt[15:8] = rx_byte;
        if (col_r == COL_YEAR_LO) year_nxt[7:0] = rx_byte;
        if (col_r == COL_AMPM)
          ampm_nxt = (rx_byte == CH_A) ? AMPM_AM : (rx_byte == CH_P) ? AMPM_PM : AMPM_NONE;
        if (col_r == COL_CENTREX && rx_byte == CH_1) centrex_nxt = 1'b1;
        if ((col_r == COL_CALLER0 || col_r == COL_CALLER1) && !is_sp && caller_cnt_r != 2'd2)
        begin
          if (caller_cnt_r == 2'd0) caller_nxt = {rx_byte, 8'h00};
          else caller_nxt[7:0] = rx_byte;
          caller_cnt_nxt = caller_cnt_r + 1'b1;
        end
        if (col_r >= COL_CALLED_F && col_r <= COL_CALLED_L && !is_sp) begin
          if (!is_dig) nondigit_nxt = 1'b1;
          if (called_cnt_r < CALLED_CNT_W'(CALLED_DIGITS)) begin
            for (int k = 0; k < CALLED_DIGITS; k++) begin
              if (called_cnt_r == CALLED_CNT_W'(k))
                called_nxt[CALLED_W-1-4*k -: 4] = rx_byte[3:0];
            end
            called_cnt_nxt = called_cnt_r + 1'b1;
          end
        end
        if (col_r >= COL_CODE_F && col_r <= COL_CODE_L && is_dig &&
            code_cnt_r < CODE_CNT_W'(CODE_DIGITS)) begin
          for (int k = 0; k < CODE_DIGITS; k++) begin
            if (code_cnt_r == CODE_CNT_W'(k)) code_nxt[15-4*k -: 4] = rx_byte[3:0];
          end
          code_cnt_nxt = code_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      last_cr_r    <= 1'b0;
      special_r    <= 1'b0;
      date_match_r <= 1'b1;
      for (int i = 0; i < NUM_VALS; i++) val_r[i] <= '0;
      ampm_r       <= AMPM_NONE;
      derr_r       <= '0;
      year_r       <= '0;
      caller_r     <= '0;
      caller_cnt_r <= '0;
      code_r       <= CODE_FILL;
      code_cnt_r   <= '0;
      called_r     <= {FILL60, FILL60};
      called_cnt_r <= '0;
      nondigit_r   <= 1'b0;
      centrex_r    <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      last_cr_r    <= last_cr_nxt;
      special_r    <= special_nxt;
      date_match_r <= date_match_nxt;
      val_r        <= val_nxt;
      ampm_r       <= ampm_nxt;
      derr_r       <= derr_nxt;
      year_r       <= year_nxt;
      caller_r     <= caller_nxt;
      caller_cnt_r <= caller_cnt_nxt;
      code_r       <= code_nxt;
      code_cnt_r   <= code_cnt_nxt;
      called_r     <= called_nxt;
      called_cnt_r <= called_cnt_nxt;
      nondigit_r   <= nondigit_nxt;
      centrex_r    <= centrex_nxt;
    end
  end

  // classify the finished line
  always_comb begin
    rec.ignored         = special_r || (date_match_r && col_r >= COL_PREFIX);
    rec.len_bad         = (col_r != COL_W'(REC_LEN - 1));
    rec.month           = val_r[V_MONTH];
    rec.day             = val_r[V_DAY];
    rec.hour            = val_r[V_HOUR];
    rec.minute          = val_r[V_MINUTE];
    rec.ampm            = ampm_r;
    rec.derr            = derr_r;
    rec.year            = year_r;
    rec.caller          = caller_r;
    rec.code            = code_r;
    rec.code_any        = (code_cnt_r != '0);
    rec.called          = called_r;
    rec.called_any      = (called_cnt_r != '0);
    rec.called_nondigit = nondigit_r;
    rec.centrex         = centrex_r;
    rec.dur_h           = val_r[V_DUR_H];
    rec.dur_m           = val_r[V_DUR_M];
    rec.dur_s           = val_r[V_DUR_S];
  end

endmodule

FILE: rtl/crlp_queue.sv
module crlp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  crlp_pkg::line_rec_t push_rec,
  input  logic                pop,
  output logic                head_valid,
  output crlp_pkg::line_rec_t head_rec,
  output logic                full
);
  import crlp_pkg::*;

  line_rec_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_rec   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/crlp_back.sv
module crlp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  crlp_pkg::line_rec_t        head_rec,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [3:0]                 out_status,
  output logic [15:0]                out_year_text,
  output logic [3:0]                 out_start_month,
  output logic [4:0]                 out_start_day,
  output logic [4:0]                 out_start_hour,
  output logic [5:0]                 out_start_minute,
  output logic [crlp_pkg::DUR_W-1:0] out_duration_seconds,
  output logic [15:0]                out_caller_text,
  output logic [15:0]                out_code_digits,
  output logic [crlp_pkg::HALF_W-1:0] out_called_first_half,
  output logic [crlp_pkg::HALF_W-1:0] out_called_second_half
);
  import crlp_pkg::*;

  logic              valid_r;
  logic [3:0]        status_r;
  logic [15:0]       year_r, caller_r, code_r;
  logic [3:0]        month_r;
  logic [4:0]        day_r, hour_r;
  logic [5:0]        minute_r;
  logic [DUR_W-1:0]  dur_r;
  logic [HALF_W-1:0] first_r, second_r;

  logic              load;
  logic [VAL_W-1:0]  hour24;
  logic [DUR_W-1:0]  dur;
  logic [3:0]        st;
  logic              ok;

  assign load = head_valid && (!valid_r || !out_stall);
  assign pop  = load;

  always_comb begin
    hour24 = head_rec.hour;
    if (head_rec.ampm == AMPM_AM && head_rec.hour == VAL_W'(12)) hour24 = '0;
    if (head_rec.ampm == AMPM_PM && head_rec.hour != VAL_W'(12))
      hour24 = head_rec.hour + VAL_W'(12);
    dur = DUR_W'(head_rec.dur_h) * DUR_W'(SEC_PER_HOUR)
        + DUR_W'(head_rec.dur_m) * DUR_W'(SEC_PER_MIN)
        + DUR_W'(head_rec.dur_s);
    if (head_rec.ignored)                                                st = ST_IGNORED;
    else if (head_rec.len_bad)                                           st = ST_LENGTH;
    else if (head_rec.derr[ERR_MONTH]  || head_rec.month  > VAL_W'(12))  st = ST_MONTH;
    else if (head_rec.derr[ERR_DAY]    || head_rec.day    > VAL_W'(31))  st = ST_DAY;
    else if (head_rec.derr[ERR_HOUR]   || hour24          > VAL_W'(23))  st = ST_HOUR;
    else if (head_rec.derr[ERR_MINUTE] || head_rec.minute > VAL_W'(59))  st = ST_MINUTE;
    else if (head_rec.derr[ERR_DUR])                                     st = ST_DUR_BAD;
    else if (dur == '0)                                                  st = ST_ZERO_DUR;
    else if (head_rec.centrex)                                           st = ST_CENTREX;
    else if (head_rec.called_nondigit)                                   st = ST_CALLED;
    else                                                                 st = ST_OK;
    ok = (st == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload: every field but status reads zero on a failed line
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= st;
      year_r   <= ok ? head_rec.year : 16'h0;
      month_r  <= ok ? head_rec.month[3:0] : 4'h0;
      day_r    <= ok ? head_rec.day[4:0] : 5'h0;
      hour_r   <= ok ? hour24[4:0] : 5'h0;
      minute_r <= ok ? head_rec.minute[5:0] : 6'h0;
      dur_r    <= ok ? dur : '0;
      caller_r <= ok ? head_rec.caller : 16'h0;
      code_r   <= !ok ? 16'h0 : head_rec.code_any ? head_rec.code : CODE_ZERO;
      first_r  <= !ok ? '0 :
                  head_rec.called_any ? head_rec.called[CALLED_W-1:HALF_W] : ZERO_NUM;
      second_r <= !ok ? '0 :
                  head_rec.called_any ? head_rec.called[HALF_W-1:0] : FILL60;
    end
  end

  assign out_valid              = valid_r;
  assign out_status             = status_r;
  assign out_year_text          = year_r;
  assign out_start_month        = month_r;
  assign out_start_day          = day_r;
  assign out_start_hour         = hour_r;
  assign out_start_minute       = minute_r;
  assign out_duration_seconds   = dur_r;
  assign out_caller_text        = caller_r;
  assign out_code_digits        = code_r;
  assign out_called_first_half  = first_r;
  assign out_called_second_half = second_r;

endmodule
